// ===== rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 message digest block.
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;

	localparam logic [255:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/sha256_core.sv =====
// SHA-256 compression core: schedule memory, round logic, chaining words.
module sha256_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        wr_en,
	input  logic [3:0]  wr_addr,
	input  logic [31:0] wr_data,
	input  logic        reinit,
	input  logic [2:0]  h_sel,
	output logic [31:0] h_word,
	output logic        busy,
	output logic        done
);

	typedef enum logic [1:0] {IDLE, PRIME, ROUND, FOLD} state_t;

	state_t      state_q;
	logic [5:0]  t_q;
	logic [31:0] w_mem [16];
	logic [31:0] w_rd_q;
	logic [3:0]  rd_addr;
	logic [31:0] ring_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [255:0] hv_q;
	logic [31:0] w_new, w_cur, t1, t2, x15, x2, x16, x7;
	logic [5:0]  t_next;

	// Sixteen-word window kept in a shift line for the schedule taps; the memory
	// holds the loaded block words read one per cycle.
	assign t_next  = t_q + 6'd1;
	assign rd_addr = (state_q == ROUND) ? t_next[3:0] : 4'd0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_mem[wr_addr] <= wr_data;
		end
		w_rd_q <= w_mem[rd_addr];
	end

	assign x16 = ring_q[0];
	assign x15 = ring_q[1];
	assign x7  = ring_q[9];
	assign x2  = ring_q[14];
	assign w_new = x16 + (sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3))
		+ x7 + (sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10));
	assign w_cur = t_q[5:4] == 2'd0 ? w_rd_q : w_new;

	assign t1 = h_q + (sha256_pkg::rotr(e_q, 6) ^ sha256_pkg::rotr(e_q, 11)
		^ sha256_pkg::rotr(e_q, 25)) + ((e_q & f_q) ^ (~e_q & g_q))
		+ sha256_pkg::round_k(t_q) + w_cur;
	assign t2 = (sha256_pkg::rotr(a_q, 2) ^ sha256_pkg::rotr(a_q, 13)
		^ sha256_pkg::rotr(a_q, 22)) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	assign h_word = hv_q[255 - 32 * h_sel -: 32];
	assign busy   = state_q != IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			t_q     <= '0;
			done    <= 1'b0;
			hv_q    <= sha256_pkg::INIT_H;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (reinit) begin
						hv_q <= sha256_pkg::INIT_H;
					end
					if (start) begin
						state_q <= PRIME;
						t_q     <= '0;
					end
				end
				PRIME: begin
					state_q <= ROUND;
					{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= hv_q;
				end
				ROUND: begin
					for (int i = 0; i < 15; i++) begin
						ring_q[i] <= ring_q[i + 1];
					end
					ring_q[15] <= w_cur;
					h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
					t_q <= t_next;
					if (t_q == 6'd63) begin
						state_q <= FOLD;
					end
				end
				FOLD: begin
					hv_q <= {hv_q[255:224] + a_q, hv_q[223:192] + b_q,
						hv_q[191:160] + c_q, hv_q[159:128] + d_q,
						hv_q[127:96] + e_q, hv_q[95:64] + f_q,
						hv_q[63:32] + g_q, hv_q[31:0] + h_q};
					done    <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/sha256_message_digest_top.sv =====
// Top level of the streaming SHA-256 hasher: byte packing, padding, digest output.
// A byte that does not complete a block is taken without a stall; the byte that
// completes a block stalls the input while it is compressed (start, load, 64 rounds, fold, handoff).
// End of message: padding bytes up to the block end, one or two compressions, then
// eight digest beats, one per cycle while out is not stalled.
// Throughput is one item per cycle except while a block is compressed or padded or the digest is emitted.
// Reset clears the counters and loads the SHA-256 initial hash values.
module sha256_message_digest_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sha256_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sha256_pkg::out_item_t out_data
);

	typedef enum logic [2:0] {ACCEPT, COMP, PAD, LAST, FINAL, EMIT, PADCOMP} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] count_q;
	logic [23:0] pack_q;
	logic [2:0]  idx_q;
	logic        take;
	logic [7:0]  pad_byte;
	logic [63:0] bits;
	logic        start, wr_en, reinit;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;
	logic [31:0] h_word;
	logic        busy, done;
	logic [7:0]  wbyte;
	logic        wstep;
	logic        core_wait_q;
	logic        end_q;
	logic        len_ok_q;

	sha256_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.reinit  (reinit),
		.h_sel   (idx_q),
		.h_word  (h_word),
		.busy    (busy),
		.done    (done)
	);

	assign in_stall = state_q != ACCEPT;
	assign take     = in_valid && !in_stall;
	assign bits     = {count_q[60:0], 3'b000};

	always_comb begin
		pad_byte = 8'h00;
		if (len_ok_q && fill_q >= sha256_pkg::LENGTH_POS) begin
			pad_byte = bits[63 - 8 * fill_q[2:0] -: 8];
		end
	end

	always_comb begin
		wstep = 1'b0;
		wbyte = 8'h00;
		unique case (state_q)
			ACCEPT: begin
				wstep = take && in_data.byte_present;
				wbyte = in_data.data_byte;
			end
			FINAL: begin
				wstep = 1'b1;
				wbyte = sha256_pkg::PAD_MARK;
			end
			PAD: begin
				wstep = 1'b1;
				wbyte = pad_byte;
			end
			default: begin
				wstep = 1'b0;
			end
		endcase
	end

	assign wr_en   = wstep && fill_q[1:0] == 2'd3;
	assign wr_addr = fill_q[5:2];
	assign wr_data = {pack_q, wbyte};
	assign start   = !core_wait_q
		&& (state_q == COMP || state_q == PADCOMP || state_q == LAST);
	assign reinit  = state_q == EMIT && out_valid && !out_stall && out_data.last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ACCEPT;
			fill_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid   <= 1'b0;
			core_wait_q <= 1'b0;
			end_q       <= 1'b0;
			len_ok_q    <= 1'b0;
		end else begin
			if (wstep) begin
				pack_q <= {pack_q[15:0], wbyte};
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ACCEPT: begin
					if (take) begin
						end_q <= in_data.end_of_message;
						if (in_data.byte_present) begin
							count_q <= count_q + 64'd1;
						end
						if (in_data.byte_present && fill_q == 6'd63) begin
							state_q <= COMP;
						end else if (in_data.end_of_message) begin
							state_q <= FINAL;
						end
					end
				end
				COMP, PADCOMP, LAST: begin
					if (start) begin
						core_wait_q <= 1'b1;
					end else if (done) begin
						core_wait_q <= 1'b0;
						if (state_q == LAST) begin
							state_q   <= EMIT;
							idx_q     <= '0;
							out_valid <= 1'b1;
						end else if (state_q == PADCOMP) begin
							len_ok_q <= 1'b1;
							state_q  <= PAD;
						end else if (end_q) begin
							state_q <= FINAL;
						end else begin
							state_q <= ACCEPT;
						end
					end
				end
				FINAL: begin
					len_ok_q <= fill_q < sha256_pkg::LENGTH_POS;
					if (fill_q == 6'd63) begin
						state_q <= PADCOMP;
					end else begin
						state_q <= PAD;
					end
				end
				PAD: begin
					if (fill_q == 6'd63) begin
						state_q <= len_ok_q ? LAST : PADCOMP;
					end
				end
				EMIT: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							out_valid <= 1'b0;
							count_q   <= '0;
							state_q   <= ACCEPT;
						end
					end
				end
				default: state_q <= ACCEPT;
			endcase
		end
	end

	assign out_data.digest_word = h_word;
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = idx_q == 3'd7;

`ifndef NO_ASSERTIONS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("input taken while core busy");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last_word) |-> idx_q == 3'd7)
		else $error("last word flag misplaced");
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EMIT) |-> fill_q == 6'd0) else $error("fill not cleared at digest");
`endif

endmodule

// ===== tb/sha256_message_digest_checker.sv =====
// Digest predictor and output checker for the streaming SHA-256 hasher.
`timescale 1ns / 1ps
module sha256_message_digest_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  sha256_pkg::in_item_t  in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  sha256_pkg::out_item_t out_data,
	output int                    error_count,
	output int                    pending_words,
	output int                    digest_count
);
	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] H_START [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]           hash_words [8];
	logic [7:0]            block_bytes [64];
	int                    fill;
	logic [63:0]           byte_total;
	sha256_pkg::out_item_t digest_queue [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_words[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_words[i] += v[i];
	endtask

	task automatic absorb_beat(input sha256_pkg::in_item_t item);
		logic [63:0]           bits;
		sha256_pkg::out_item_t word;
		if (item.byte_present) begin
			block_bytes[fill] = item.data_byte;
			fill++;
			byte_total++;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		end
		if (item.end_of_message) begin
			bits = byte_total << 3;
			block_bytes[fill] = sha256_pkg::PAD_MARK;
			fill++;
			if (fill > 56) begin
				while (fill < 64) begin
					block_bytes[fill] = 8'h00;
					fill++;
				end
				compress_block();
				fill = 0;
			end
			while (fill < 56) begin
				block_bytes[fill] = 8'h00;
				fill++;
			end
			for (int i = 0; i < 8; i++)
				block_bytes[56+i] = bits[63-8*i -: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				word.digest_word = hash_words[i];
				word.word_index  = 3'(i);
				word.last_word   = (i == 7);
				digest_queue.push_back(word);
			end
			hash_words = H_START;
			fill = 0;
			byte_total = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sha256_pkg::out_item_t want;
		if (!arst_n) begin
			hash_words = H_START;
			fill = 0;
			byte_total = '0;
			digest_queue.delete();
			error_count = 0;
			digest_count = 0;
		end else begin
			if (in_valid && !in_stall)
				absorb_beat(in_data);
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					$error("unexpected digest beat %h", out_data);
					error_count++;
				end else begin
					want = digest_queue.pop_front();
					if (out_data.digest_word !== want.digest_word) begin
						$error("digest_word expected %h actual %h", want.digest_word,
							out_data.digest_word);
						error_count++;
					end
					if (out_data.word_index !== want.word_index) begin
						$error("word_index expected %0d actual %0d", want.word_index,
							out_data.word_index);
						error_count++;
					end
					if (out_data.last_word !== want.last_word) begin
						$error("last_word expected %0d actual %0d", want.last_word,
							out_data.last_word);
						error_count++;
					end
					if (want.last_word)
						digest_count++;
				end
			end
		end
		pending_words = digest_queue.size();
	end
endmodule

// ===== tb/sha256_message_digest_top_test.sv =====
// Stimulus, idle patterns and verdict for the streaming SHA-256 hasher.
`timescale 1ns / 1ps
module sha256_message_digest_top_test;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	sha256_pkg::in_item_t  in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	sha256_pkg::out_item_t out_data;
	int                    error_count, pending_words, digest_count;
	int                    send_idle_pct = 0, recv_stall_pct = 0;
	int                    beat_count = 0;
	longint                cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sha256_message_digest_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	sha256_message_digest_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.error_count(error_count), .pending_words(pending_words), .digest_count(digest_count)
	);

	always @(posedge clk) begin
		cycle_count++;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (cycle_count > 2000000) begin
			$display("sha256_message_digest_top_test: done, errors");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, byte_present: present, end_of_message: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beat_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
		end
		if (len == 0 || in_data.end_of_message == 1'b0)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h61, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b1);
		for (int i = 0; i < 19; i++)
			send_beat(8'(i * 13), 1'b1, i == 18);
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 85 : ((phase == 3) ? 9 : 0);
			recv_stall_pct = (phase == 2) ? 85 : ((phase == 3) ? 9 : 0);
			for (int m = 0; m < 2; m++) begin
				if (m == 0 && phase == 1)
					send_message(56);
				else if (m == 0 && phase == 3)
					send_message(63);
				else
					send_message($urandom_range(9));
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d beats; %0d digests checked, empty to multi-block messages.",
			beat_count, digest_count);
		if (error_count == 0)
			$display("sha256_message_digest_top_test: done, clean");
		else
			$display("sha256_message_digest_top_test: done, errors");
		$finish;
	end
endmodule
